@@ design/tpd_pkg.sv @@
// Shared constants, codes and result type for the tagged parameter deframer.
package tpd_pkg;

  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned CNT_W      = 16;
  localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'((33'd1 << COUNT_BITS) - 33'd1);

  localparam logic [7:0] INT_MARK  = 8'hff;
  localparam logic [7:0] INT_BYTES = 8'd4;

  localparam int unsigned CFG_AW = 3;
  localparam logic REG_DEBUG = 1'b0;

  localparam logic [2:0] ROLE_INT_IND  = 3'd0;
  localparam logic [2:0] ROLE_STR_LEN  = 3'd1;
  localparam logic [2:0] ROLE_INT_BYTE = 3'd2;
  localparam logic [2:0] ROLE_STR_CHAR = 3'd3;
  localparam logic [2:0] ROLE_DISCARD  = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TRUNC_INT = 2'd1;
  localparam logic [1:0] ST_TRUNC_STR = 2'd2;
  localparam logic [1:0] ST_FN_INT    = 2'd3;

  localparam int unsigned OUT_DW = 72;
  localparam int unsigned OUT_UW = 3;

  typedef struct packed {
    logic [7:0]       param_index;
    logic [2:0]       byte_role;
    logic [7:0]       data_byte;
    logic [31:0]      int_value;
    logic             param_done;
    logic             param_is_int;
    logic             is_function_name;
    logic [1:0]       status;
    logic             message_done;
    logic [CNT_W-1:0] consumed;
  } res_t;

endpackage

@@ design/tagged_parameter_deframer.sv @@
// Top level of the tagged parameter deframer: input register, parser, result register.
// One result per input byte, one byte per clock sustained while out_tready stays high. A
// byte is captured in the input register, parsed by combinational logic as it moves to the
// result register, and the parser state updates at that same edge. The input side keeps
// accepting while a result waits; it stalls only when both registers are full and the
// result side holds tready low. Results come out in byte order. debug_mode is written
// through the APB port at address 0 and should change only between messages.
module tagged_parameter_deframer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // [7:0] in_byte
  input  logic                       in_tlast,   // end_of_message
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // [7:0] param_index, [15:8] data_byte, [47:16] int_value, [48] param_done,
  // [49] param_is_int, [50] is_function_name, [52:51] status, [68:53] consumed, rest 0
  output logic [tpd_pkg::OUT_DW-1:0] out_tdata,
  output logic [tpd_pkg::OUT_UW-1:0] out_tuser,  // [2:0] byte_role
  output logic                       out_tlast,  // message_done
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [tpd_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);
  import tpd_pkg::*;

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       out_valid_r;
  res_t       out_res_r;
  res_t       res;
  logic       advance;
  logic       debug_mode;

  tpd_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .debug_mode (debug_mode)
  );

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  tpd_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .in_byte   (in_byte_r),
    .in_last   (in_last_r),
    .debug_mode(debug_mode),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.byte_role;
  assign out_tlast  = out_res_r.message_done;
  assign out_tdata  = {3'd0,
                       out_res_r.consumed,
                       out_res_r.status,
                       out_res_r.is_function_name,
                       out_res_r.param_is_int,
                       out_res_r.param_done,
                       out_res_r.int_value,
                       out_res_r.data_byte,
                       out_res_r.param_index};

endmodule

@@ design/tpd_cfg.sv @@
// APB-style register port holding the debug mode bit.
module tpd_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [tpd_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]               cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready,
  output logic                      debug_mode
);
  import tpd_pkg::*;

  logic debug_r;
  logic wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debug_r <= 1'b0;
    end else if (wr_en && cfg_paddr[2] == REG_DEBUG) begin
      debug_r <= cfg_pwdata[0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_DEBUG) ? {31'd0, debug_r} : 32'd0;
  assign debug_mode = debug_r;

endmodule

@@ design/tpd_parse.sv @@
// Parser state and the per-byte next-state and result logic.
module tpd_parse (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_en,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  input  logic          debug_mode,
  output tpd_pkg::res_t res
);
  import tpd_pkg::*;

  localparam logic [1:0] PH_IND     = 2'd0;
  localparam logic [1:0] PH_INT     = 2'd1;
  localparam logic [1:0] PH_STR     = 2'd2;
  localparam logic [1:0] PH_DISCARD = 2'd3;

  logic [1:0]       phase_r, phase_nxt;
  logic [7:0]       left_r, left_nxt;
  logic [23:0]      acc_r, acc_nxt;
  logic [7:0]       pcnt_r, pcnt_nxt;
  logic [CNT_W-1:0] commit_r, commit_nxt;
  logic [8:0]       cpb_r, cpb_nxt;

  logic [2:0]   role;
  logic         done, is_int, is_fn, complete;
  logic [1:0]   status;
  logic [31:0]  ival;
  logic [1:0]   k;
  logic [31:0]  shifted;
  logic [CNT_W:0] sum;
  logic [CNT_W-1:0] consumed;

  // byte lane of the next integer byte
  assign k = 2'(3'd4 - left_r[2:0]);
  assign shifted = {24'd0, in_byte} << {k, 3'b000};

  always_comb begin
    role = ROLE_DISCARD;
    done = 1'b0;
    is_int = 1'b0;
    status = ST_OK;
    ival = 32'd0;
    complete = 1'b0;
    consumed = '0;
    sum = '0;
    phase_nxt = phase_r;
    left_nxt = left_r;
    acc_nxt = acc_r;
    pcnt_nxt = pcnt_r;
    commit_nxt = commit_r;
    cpb_nxt = cpb_r;
    is_fn = (phase_r != PH_DISCARD) && (pcnt_r == 8'd0);

    unique case (phase_r)
      PH_DISCARD: begin
        status = ST_FN_INT;
      end
      PH_IND: begin
        cpb_nxt = 9'd1;
        if (in_byte == INT_MARK) begin
          role = ROLE_INT_IND;
          is_int = 1'b1;
          phase_nxt = PH_INT;
          left_nxt = INT_BYTES;
          acc_nxt = 24'd0;
        end else begin
          role = ROLE_STR_LEN;
          if (in_byte == 8'd0) begin
            complete = 1'b1;
          end else begin
            phase_nxt = PH_STR;
            left_nxt = in_byte;
          end
        end
      end
      PH_INT: begin
        role = ROLE_INT_BYTE;
        is_int = 1'b1;
        cpb_nxt = cpb_r + 9'd1;
        if (left_r <= 8'd1) begin
          ival = {in_byte, acc_r};
          left_nxt = 8'd0;
          complete = 1'b1;
        end else begin
          acc_nxt = acc_r | shifted[23:0];
          left_nxt = left_r - 8'd1;
        end
      end
      PH_STR: begin
        role = ROLE_STR_CHAR;
        cpb_nxt = cpb_r + 9'd1;
        if (left_r <= 8'd1) begin
          left_nxt = 8'd0;
          complete = 1'b1;
        end else begin
          left_nxt = left_r - 8'd1;
        end
      end
      default: begin
        status = ST_FN_INT;
      end
    endcase

    if (complete) begin
      done = 1'b1;
      phase_nxt = PH_IND;
      if (is_int && is_fn && !debug_mode) begin
        status = ST_FN_INT;
        phase_nxt = PH_DISCARD;
      end else begin
        sum = {1'b0, commit_r} + (CNT_W+1)'(cpb_nxt);
        commit_nxt = (sum > {1'b0, COUNT_LIMIT}) ? COUNT_LIMIT : sum[CNT_W-1:0];
        if (pcnt_r != 8'd255) begin
          pcnt_nxt = pcnt_r + 8'd1;
        end
      end
      cpb_nxt = 9'd0;
    end else if (in_last && phase_r != PH_DISCARD) begin
      status = (phase_nxt == PH_INT) ? ST_TRUNC_INT : ST_TRUNC_STR;
    end

    if (in_last) begin
      consumed = commit_nxt;
      phase_nxt = PH_IND;
      left_nxt = 8'd0;
      acc_nxt = 24'd0;
      pcnt_nxt = 8'd0;
      commit_nxt = '0;
      cpb_nxt = 9'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IND;
      left_r <= 8'd0;
      acc_r <= 24'd0;
      pcnt_r <= 8'd0;
      commit_r <= '0;
      cpb_r <= 9'd0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      left_r <= left_nxt;
      acc_r <= acc_nxt;
      pcnt_r <= pcnt_nxt;
      commit_r <= commit_nxt;
      cpb_r <= cpb_nxt;
    end
  end

  always_comb begin
    res.param_index = pcnt_r;
    res.byte_role = role;
    res.data_byte = in_byte;
    res.int_value = ival;
    res.param_done = done;
    res.param_is_int = is_int;
    res.is_function_name = is_fn;
    res.status = status;
    res.message_done = in_last;
    res.consumed = consumed;
  end

endmodule

@@ design/tpd_checker.sv @@
// Port-level checks for the tagged parameter deframer and their bind.
module tpd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [tpd_pkg::OUT_DW-1:0] out_tdata,
  input logic [tpd_pkg::OUT_UW-1:0] out_tuser,
  input logic                       out_tlast
);
  import tpd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_discard_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ROLE_DISCARD |-> out_tdata[52:51] == ST_FN_INT
      && out_tdata[48] == 1'b0 && out_tdata[47:16] == 32'd0)
    else $error("discarded byte with wrong flags");

  a_consumed_eom: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[68:53] == '0)
    else $error("consumed count outside end of message");

  a_int_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[47:16] != 32'd0 |-> out_tdata[48] && out_tdata[49]
      && out_tuser == ROLE_INT_BYTE)
    else $error("integer value without completed integer");

endmodule

bind tagged_parameter_deframer tpd_checker u_tpd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);

@@ tb/tb_tagged_parameter_deframer.sv @@
`timescale 1ns / 1ps
// Testbench for tagged_parameter_deframer: random and directed byte streams checked per request.
module tb_tagged_parameter_deframer;
  import tpd_pkg::*;

  typedef enum logic [1:0] {PH_WAIT_IND, PH_INT_BODY, PH_STR_BODY, PH_SKIP} parse_ph_t;
  typedef logic [7:0] byte_q_t[$];
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } req_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata = '0;
  logic                in_tlast = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_DW-1:0]   out_tdata;
  logic [OUT_UW-1:0]   out_tuser;
  logic                out_tlast;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]   cfg_paddr = '0;
  logic [31:0]         cfg_pwdata = '0;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  tagged_parameter_deframer dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // parser state mirror
  parse_ph_t        ps_phase;
  logic [7:0]       ps_left;
  logic [23:0]      ps_acc;
  logic [7:0]       ps_idx;
  logic [CNT_W-1:0] ps_total;
  logic [8:0]       ps_cur;
  logic             ps_dbg;

  req_t   byte_feed[$];
  res_t   result_due[$];
  int     err_cnt = 0;
  int     fed_cnt = 0;
  int     taken_cnt = 0;
  int     feed_gap = 0;
  int     ready_gap = 0;
  int     hold_left = 0;
  bit     held = 1'b0;
  bit     calm = 1'b0;
  int     cyc = 0;

  function automatic void clear_parse();
    ps_phase = PH_WAIT_IND;
    ps_left  = '0;
    ps_acc   = '0;
    ps_idx   = '0;
    ps_total = '0;
    ps_cur   = '0;
  endfunction

  function automatic res_t parse_byte(input logic [7:0] b, input logic eom);
    res_t        r;
    logic        done_now;
    logic [16:0] sum;
    logic [1:0]  k;
    r = '0;
    done_now = 1'b0;
    r.param_index = ps_idx;
    r.byte_role = ROLE_DISCARD;
    r.data_byte = b;
    r.message_done = eom;
    if (ps_phase == PH_SKIP) begin
      r.status = ST_FN_INT;
    end else begin
      r.is_function_name = (ps_idx == 8'd0);
      case (ps_phase)
        PH_WAIT_IND: begin
          ps_cur = 9'd1;
          if (b == INT_MARK) begin
            r.byte_role = ROLE_INT_IND;
            r.param_is_int = 1'b1;
            ps_phase = PH_INT_BODY;
            ps_left = INT_BYTES;
            ps_acc = '0;
          end else begin
            r.byte_role = ROLE_STR_LEN;
            if (b == 8'd0) begin
              done_now = 1'b1;
            end else begin
              ps_phase = PH_STR_BODY;
              ps_left = b;
            end
          end
        end
        PH_INT_BODY: begin
          r.byte_role = ROLE_INT_BYTE;
          r.param_is_int = 1'b1;
          ps_cur = ps_cur + 9'd1;
          if (ps_left <= 8'd1) begin
            r.int_value = {b, ps_acc};
            ps_left = '0;
            done_now = 1'b1;
          end else begin
            k = 2'(INT_BYTES - ps_left);
            ps_acc = ps_acc | (24'(b) << (8 * k));
            ps_left = ps_left - 8'd1;
          end
        end
        default: begin
          r.byte_role = ROLE_STR_CHAR;
          ps_cur = ps_cur + 9'd1;
          if (ps_left <= 8'd1) begin
            ps_left = '0;
            done_now = 1'b1;
          end else begin
            ps_left = ps_left - 8'd1;
          end
        end
      endcase
      if (done_now) begin
        r.param_done = 1'b1;
        ps_phase = PH_WAIT_IND;
        if (r.param_is_int && r.is_function_name && !ps_dbg) begin
          r.status = ST_FN_INT;
          ps_phase = PH_SKIP;
        end else begin
          sum = {1'b0, ps_total} + 17'(ps_cur);
          ps_total = (sum > 17'(COUNT_LIMIT)) ? COUNT_LIMIT : sum[CNT_W-1:0];
          if (ps_idx != 8'hff) ps_idx = ps_idx + 8'd1;
        end
        ps_cur = '0;
      end else if (eom) begin
        r.status = (ps_phase == PH_INT_BODY) ? ST_TRUNC_INT : ST_TRUNC_STR;
      end
    end
    if (eom) begin
      r.consumed = ps_total;
      clear_parse();
    end
    return r;
  endfunction

  function automatic string show(input res_t r);
    return $sformatf({"idx=%0d role=%0d byte=%02h int=%08h done=%0b int=%0b fn=%0b",
                      " st=%0d eom=%0b cnt=%0d"},
                     r.param_index, r.byte_role, r.data_byte, r.int_value, r.param_done,
                     r.param_is_int, r.is_function_name, r.status, r.message_done, r.consumed);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // sender
  always @(posedge clk) begin
    req_t nx;
    res_t pr;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      feed_gap <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        pr = parse_byte(in_tdata, in_tlast);
        result_due = {result_due, pr};
        taken_cnt++;
      end
      if (!in_tvalid || in_tready) begin
        if (feed_gap != 0) begin
          in_tvalid <= 1'b0;
          feed_gap <= feed_gap - 1;
        end else if (byte_feed.size() != 0) begin
          nx = byte_feed.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= nx.data;
          in_tlast <= nx.last;
          feed_gap <= pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off and calm stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      held <= 1'b0;
      cyc <= 0;
      calm <= 1'b0;
    end else begin
      cyc <= cyc + 1;
      if (!held && taken_cnt >= 300) begin
        hold_left <= 400;
        held <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
      if (cyc % 512 == 0) calm <= ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      ready_gap <= 0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
    end else if (ready_gap != 0) begin
      out_tready <= 1'b0;
      ready_gap <= ready_gap - 1;
    end else begin
      out_tready <= 1'b1;
      ready_gap <= pick_gap();
    end
  end

  // result checker
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.param_index      = out_tdata[7:0];
      got.data_byte        = out_tdata[15:8];
      got.int_value        = out_tdata[47:16];
      got.param_done       = out_tdata[48];
      got.param_is_int     = out_tdata[49];
      got.is_function_name = out_tdata[50];
      got.status           = out_tdata[52:51];
      got.consumed         = out_tdata[68:53];
      got.byte_role        = out_tuser[2:0];
      got.message_done     = out_tlast;
      if (result_due.size() == 0) begin
        if (err_cnt < 10) $display("unexpected result: %s", show(got));
        err_cnt++;
      end else begin
        want = result_due.pop_front();
        if (got !== want || out_tdata[OUT_DW-1:69] !== '0) begin
          if (err_cnt < 10) begin
            $display("mismatch: expected %s", show(want));
            $display("          actual   %s pad=%h", show(got), out_tdata[OUT_DW-1:69]);
          end
          err_cnt++;
        end
      end
    end
  end

  task automatic send_msg(input byte_q_t m);
    req_t rq;
    for (int i = 0; i < m.size(); i++) begin
      rq.data = m[i];
      rq.last = (i == m.size() - 1);
      byte_feed = {byte_feed, rq};
      fed_cnt++;
    end
  endtask

  task automatic cfg_write(input logic val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_AW'(4 * REG_DEBUG);
    cfg_pwdata <= 32'(val);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    ps_dbg = val;
  endtask

  task automatic drain();
    while (byte_feed.size() != 0 || in_tvalid || result_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic int rand_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 6);
    if (r < 95) return $urandom_range(7, 40);
    return $urandom_range(41, 254);
  endfunction

  task automatic add_str(ref byte_q_t m, input int len);
    m = {m, 8'(len)};
    repeat (len) m = {m, 8'($urandom)};
  endtask

  task automatic add_int(ref byte_q_t m);
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0: v = 32'h0000_0000;
      1: v = 32'h7fff_ffff;
      2: v = 32'h8000_0000;
      3: v = 32'hffff_ffff;
      default: v = $urandom;
    endcase
    m = {m, INT_MARK};
    for (int i = 0; i < 4; i++) m = {m, v[8*i +: 8]};
  endtask

  task automatic gen_msg();
    byte_q_t m;
    byte_q_t p;
    int n;
    int keep;
    m = {};
    p = {};
    if ($urandom_range(0, 99) < 5) begin
      n = $urandom_range(1, 12);
      repeat (n) m = {m, 8'($urandom)};
    end else begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        if ((i == 0) ? ($urandom_range(0, 4) == 0) : ($urandom_range(0, 2) == 0)) add_int(m);
        else add_str(m, rand_len());
      end
      if ($urandom_range(0, 5) == 0) begin
        if ($urandom_range(0, 1) == 0) add_int(p);
        else add_str(p, $urandom_range(1, 20));
        keep = $urandom_range(1, p.size() - 1);
        for (int i = 0; i < keep; i++) m = {m, p[i]};
      end
    end
    send_msg(m);
  endtask

  initial begin
    byte_q_t m;
    int target;
    clear_parse();
    ps_dbg = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    cfg_write(1'b0);
    m = {8'h02, 8'h61, 8'h62, 8'hff, 8'h01, 8'h00, 8'h00, 8'h80, 8'h00};
    send_msg(m);
    // integer function name, rest of message dropped
    m = {8'hff, 8'h11, 8'h22, 8'h33, 8'h44, 8'h05, 8'h78};
    send_msg(m);
    m = {8'h01, 8'h66, 8'hff, 8'h12, 8'h34};
    send_msg(m);
    m = {8'h03, 8'h61};
    send_msg(m);
    m = {8'hff};
    send_msg(m);
    m = {8'h00};
    send_msg(m);
    m = {8'hfe};
    send_msg(m);
    drain();

    cfg_write(1'b1);
    m = {8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00};
    send_msg(m);
    m = {8'hff, 8'h00, 8'h00, 8'h00, 8'h00};
    send_msg(m);

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      cfg_write(1'(ph & 1));
      target = fed_cnt + 90;
      while (fed_cnt < target) gen_msg();
    end

    // one long message: parameter index saturates
    drain();
    cfg_write(1'b0);
    m = {};
    for (int i = 0; i < 260; i++) begin
      add_str(m, 0);
      if (i == 130) add_int(m);
    end
    add_str(m, 3);
    send_msg(m);
    drain();
    repeat (10) @(posedge clk);

    err_cnt += result_due.size();
    if (err_cnt == 0) begin
      $display("tb_tagged_parameter_deframer: done, clean");
    end else begin
      $display("tb_tagged_parameter_deframer: done, errors");
    end
    $finish;
  end

  initial begin
    #150_000_000;
    $display("tb_tagged_parameter_deframer: done, errors");
    $finish;
  end

endmodule

@@ sim.f @@
design/tpd_pkg.sv
design/tpd_cfg.sv
design/tpd_parse.sv
design/tagged_parameter_deframer.sv
design/tpd_checker.sv
tb/tb_tagged_parameter_deframer.sv
